// ===== design/micc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// micc_pkg
// Shared types and constants for the magic index collision checker.
// ----------------------------------------------------------------------------
package micc_pkg;

    localparam int WORD_W    = 64;
    localparam int HALF_W    = 32;
    localparam int OUT_IDX_W = 12;
    localparam int CNT_W     = 13;
    localparam int SHIFT_W   = 6;
    localparam int EPOCH_W   = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [CNT_W-1:0]   CNT_MAX     = '1;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd52;

    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MAGIC = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT = 1'b1;

    typedef enum logic [2:0] {
        ST_STORED       = 3'd0,
        ST_CONSTRUCTIVE = 3'd1,
        ST_DESTRUCTIVE  = 3'd2,
        ST_IGNORED      = 3'd3,
        ST_BEGUN        = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_IDX,
        S_READ,
        S_EVAL
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load_in;
        logic mul;
        logic idx;
        logic eval;
        logic clr_step;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_check;
        logic failed;
        logic is_begin;
        logic epoch_full;
        logic clr_done;
    } t_dp_stat;

endpackage

// ===== design/magic_index_collision_check_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magic_index_collision_check_core
// Hashes blocker sets with a candidate magic and checks the attack table for
// destructive collisions.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-------------------------------------
//  request   | i_in_valid / o_in_ready   | i_command, i_blocker_set,
//            |                           | i_attack_map
//  result    | o_out_valid / i_out_ready | o_table_index, o_status,
//            |                           | o_stored_count, o_constructive_count,
//            |                           | o_largest_index, o_trial_failed
//  config    | i_cfg_we                  | i_cfg_index, i_cfg_data
//
//  A check request passes through accept, partial products, index, table
//  read and evaluate; begin and ignored requests go from accept to evaluate.
//  The table read/update loop through the single RAM sets the rate; one
//  request is in flight. After reset, and after every 255th begin request,
//  a clearing pass over all 2^INDEX_BITS entries zeroes tags and maps; no
//  request is taken then. Result stalls hold the evaluate step; a new
//  request is still taken while a finished result waits in the output
//  register.
//  Occupancy is an epoch tag stored with each table entry: a begin request
//  bumps the epoch, which empties the table without writing its entries. The
//  attack maps are cleared only by the clearing pass.
// ----------------------------------------------------------------------------
module magic_index_collision_check_core
    import micc_pkg::*;
#(
    parameter int INDEX_BITS = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data,
    // request
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_command,
    input  logic [WORD_W-1:0]    i_blocker_set,
    input  logic [WORD_W-1:0]    i_attack_map,
    // result
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [OUT_IDX_W-1:0] o_table_index,
    output logic [2:0]           o_status,
    output logic [CNT_W-1:0]     o_stored_count,
    output logic [CNT_W-1:0]     o_constructive_count,
    output logic [OUT_IDX_W-1:0] o_largest_index,
    output logic                 o_trial_failed
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer
    micc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // multiply, hash, table and trial counters
    micc_datapath #(
        .INDEX_BITS (INDEX_BITS)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_command            (i_command),
        .i_blocker_set        (i_blocker_set),
        .i_attack_map         (i_attack_map),
        .i_cmd                (w_cmd),
        .o_stat               (w_stat),
        .o_table_index        (o_table_index),
        .o_status             (o_status),
        .o_stored_count       (o_stored_count),
        .o_constructive_count (o_constructive_count),
        .o_largest_index      (o_largest_index),
        .o_trial_failed       (o_trial_failed)
    );

endmodule

// ===== design/micc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// micc_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module micc_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/micc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// micc_ctrl
// Sequencer: clearing pass, request intake, multiply/index/read/evaluate steps.
// ----------------------------------------------------------------------------
module micc_ctrl
    import micc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_stat.in_check && !i_stat.failed) ? S_MUL : S_EVAL;
                end
            end
            S_MUL:  n_state = S_IDX;
            S_IDX:  n_state = S_READ;
            S_READ: n_state = S_EVAL;
            S_EVAL: begin
                if (w_out_free) begin
                    n_state = (i_stat.is_begin && i_stat.epoch_full) ? S_CLEAR : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: o_cmd.clr_step = 1'b1;
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            S_MUL:   o_cmd.mul  = 1'b1;
            S_IDX:   o_cmd.idx  = 1'b1;
            S_READ:  o_cmd      = '0;
            S_EVAL:  o_cmd.eval = w_out_free;
            default: o_cmd      = '0;
        endcase
    end

    always_comb begin
        if (o_cmd.eval) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== design/micc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// micc_datapath
// Config registers, split 64x64 multiply, index shift, tagged table, counters.
// ----------------------------------------------------------------------------
module micc_datapath
    import micc_pkg::*;
#(
    parameter int INDEX_BITS = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data,
    input  logic                 i_command,
    input  logic [WORD_W-1:0]    i_blocker_set,
    input  logic [WORD_W-1:0]    i_attack_map,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    output logic [OUT_IDX_W-1:0] o_table_index,
    output logic [2:0]           o_status,
    output logic [CNT_W-1:0]     o_stored_count,
    output logic [CNT_W-1:0]     o_constructive_count,
    output logic [OUT_IDX_W-1:0] o_largest_index,
    output logic                 o_trial_failed
);

    localparam int DEPTH = 1 << INDEX_BITS;
    localparam int RAM_W = EPOCH_W + WORD_W;
    localparam int XW    = INDEX_BITS + OUT_IDX_W;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    // config
    logic [WORD_W-1:0]  r_magic;
    logic [SHIFT_W-1:0] r_shift;

    // captured request
    logic              r_cmd_bit;
    logic [WORD_W-1:0] r_blk;
    logic [WORD_W-1:0] r_amap;

    // product pieces
    logic [WORD_W-1:0] r_p0;
    logic [HALF_W-1:0] r_p1, r_p2;
    logic [WORD_W-1:0] w_m0;
    logic [HALF_W-1:0] w_m1, w_m2;
    logic [HALF_W-1:0] w_cross;
    logic [WORD_W-1:0] w_prod, w_shifted;

    logic [INDEX_BITS-1:0] r_idx;
    logic [INDEX_BITS-1:0] r_max;
    logic [INDEX_BITS-1:0] r_out_index;
    t_status               r_out_status;

    logic [EPOCH_W-1:0]    r_epoch;
    logic [INDEX_BITS-1:0] r_clr_addr;
    logic [CNT_W-1:0]      r_stored, r_cons;
    logic                  r_failed;

    // table
    logic                  w_we;
    logic [INDEX_BITS-1:0] w_waddr;
    logic [RAM_W-1:0]      w_wdata, w_rdata;
    logic [EPOCH_W-1:0]    w_rd_tag;
    logic [WORD_W-1:0]     w_rd_map;
    logic                  w_hit, w_same, w_check, w_do_store;

    logic [XW-1:0] w_idx_x, w_max_x;

    // low 64 bits of blk * magic from three 32x32 products; the cross
    // terms only feed the upper half, so their low 32 bits are enough
    assign w_m0 = {{HALF_W{1'b0}}, r_blk[HALF_W-1:0]} *
                  {{HALF_W{1'b0}}, r_magic[HALF_W-1:0]};
    assign w_m1 = r_blk[HALF_W-1:0] * r_magic[WORD_W-1:HALF_W];
    assign w_m2 = r_blk[WORD_W-1:HALF_W] * r_magic[HALF_W-1:0];

    assign w_cross   = r_p1 + r_p2;
    assign w_prod    = r_p0 + {w_cross, {HALF_W{1'b0}}};
    assign w_shifted = w_prod >> r_shift;

    assign w_rd_tag = w_rdata[RAM_W-1 -: EPOCH_W];
    assign w_rd_map = w_rdata[WORD_W-1:0];

    // an entry is occupied when its tag matches the live epoch
    assign w_hit      = (w_rd_tag == r_epoch);
    assign w_same     = (w_rd_map == r_amap);
    assign w_check    = (r_cmd_bit == CMD_CHECK) && !r_failed;
    assign w_do_store = w_check && !w_hit;

    assign w_we    = i_cmd.clr_step || (i_cmd.eval && w_do_store);
    assign w_waddr = i_cmd.clr_step ? r_clr_addr : r_idx;
    assign w_wdata = i_cmd.clr_step ? '0 : {r_epoch, r_amap};

    micc_ram #(
        .WIDTH (RAM_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic    <= '0;
            r_shift    <= SHIFT_RESET;
            r_epoch    <= EPOCH_FIRST;
            r_clr_addr <= '0;
            r_stored   <= '0;
            r_cons     <= '0;
            r_max      <= '0;
            r_failed   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_MAGIC: r_magic <= i_cfg_data;
                    REG_SHIFT: r_shift <= i_cfg_data[SHIFT_W-1:0];
                    default:   r_magic <= r_magic;
                endcase
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.eval) begin
                if (r_cmd_bit == CMD_BEGIN) begin
                    r_stored <= '0;
                    r_cons   <= '0;
                    r_max    <= '0;
                    r_failed <= 1'b0;
                    r_epoch  <= (&r_epoch) ? EPOCH_FIRST : r_epoch + 1'b1;
                end else if (!r_failed) begin
                    if (r_idx > r_max) begin
                        r_max <= r_idx;
                    end
                    if (w_hit && !w_same) begin
                        r_failed <= 1'b1;
                    end else if (w_hit) begin
                        r_cons <= sat_inc(r_cons);
                    end else begin
                        r_stored <= sat_inc(r_stored);
                    end
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd_bit <= i_command;
            r_blk     <= i_blocker_set;
            r_amap    <= i_attack_map;
        end
        if (i_cmd.mul) begin
            r_p0 <= w_m0;
            r_p1 <= w_m1;
            r_p2 <= w_m2;
        end
        if (i_cmd.idx) begin
            r_idx <= w_shifted[INDEX_BITS-1:0];
        end
        if (i_cmd.eval) begin
            if (!w_check) begin
                r_out_index  <= '0;
                r_out_status <= (r_cmd_bit == CMD_BEGIN) ? ST_BEGUN : ST_IGNORED;
            end else begin
                r_out_index <= r_idx;
                if (w_hit && !w_same) begin
                    r_out_status <= ST_DESTRUCTIVE;
                end else if (w_hit) begin
                    r_out_status <= ST_CONSTRUCTIVE;
                end else begin
                    r_out_status <= ST_STORED;
                end
            end
        end
    end

    assign o_stat.in_check   = (i_command == CMD_CHECK);
    assign o_stat.failed     = r_failed;
    assign o_stat.is_begin   = (r_cmd_bit == CMD_BEGIN);
    assign o_stat.epoch_full = &r_epoch;
    assign o_stat.clr_done   = &r_clr_addr;

    // indexes are reported modulo the 12-bit field
    assign w_idx_x = XW'(r_out_index);
    assign w_max_x = XW'(r_max);

    assign o_table_index        = w_idx_x[OUT_IDX_W-1:0];
    assign o_status             = r_out_status;
    assign o_stored_count       = r_stored;
    assign o_constructive_count = r_cons;
    assign o_largest_index      = w_max_x[OUT_IDX_W-1:0];
    assign o_trial_failed       = r_failed;

endmodule

// ===== tb/sv/magic_index_collision_check_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magic_index_collision_check_core_tb
// Self-checking bench for the magic index collision checker. A behavioral
// copy of the hash table predicts every result. The bench runs directed cases
// for field extremes, begin/failure rules and index wrap. It then runs random
// trials under several magic/shift settings, an epoch wrap sweep and a run
// of repeated matching hits on one slot.
// ----------------------------------------------------------------------------
module magic_index_collision_check_core_tb;
    import micc_pkg::*;

    // Must match the INDEX_BITS default of the block under test.
    localparam int TBL_BITS    = 12;
    localparam int TBL_SIZE    = 1 << TBL_BITS;
    localparam int CYCLE_LIMIT = 1_000_000;

    // One result as the block reports it.
    typedef struct packed {
        logic [OUT_IDX_W-1:0] table_index;
        t_status              status;
        logic [CNT_W-1:0]     stored_count;
        logic [CNT_W-1:0]     constructive_count;
        logic [OUT_IDX_W-1:0] largest_index;
        logic                 trial_failed;
    } t_outcome;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = REG_MAGIC;
    logic [WORD_W-1:0]    i_cfg_data    = '0;
    logic                 i_in_valid    = 1'b0;
    logic                 o_in_ready;
    logic                 i_command     = CMD_CHECK;
    logic [WORD_W-1:0]    i_blocker_set = '0;
    logic [WORD_W-1:0]    i_attack_map  = '0;
    logic                 o_out_valid;
    logic                 i_out_ready   = 1'b1;
    logic [OUT_IDX_W-1:0] o_table_index;
    logic [2:0]           o_status;
    logic [CNT_W-1:0]     o_stored_count;
    logic [CNT_W-1:0]     o_constructive_count;
    logic [OUT_IDX_W-1:0] o_largest_index;
    logic                 o_trial_failed;

    magic_index_collision_check_core u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_command           (i_command),
        .i_blocker_set       (i_blocker_set),
        .i_attack_map        (i_attack_map),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_table_index       (o_table_index),
        .o_status            (o_status),
        .o_stored_count      (o_stored_count),
        .o_constructive_count(o_constructive_count),
        .o_largest_index     (o_largest_index),
        .o_trial_failed      (o_trial_failed)
    );

    // ------------------------------------------------------------------------
    // Predictor state: config copy plus the behavioral hash table
    // ------------------------------------------------------------------------
    logic [WORD_W-1:0]   magic_cfg      = '0;
    logic [SHIFT_W-1:0]  shift_cfg      = SHIFT_RESET;
    logic [WORD_W-1:0]   map_mem [TBL_SIZE];
    bit                  slot_used [TBL_SIZE];
    logic [CNT_W-1:0]    n_stored       = '0;
    logic [CNT_W-1:0]    n_constructive = '0;
    logic [TBL_BITS-1:0] top_index      = '0;
    bit                  failed         = 1'b0;

    t_outcome pending_outcomes [$];

    // Bookkeeping
    int  mismatches     = 0;
    int  requests_sent  = 0;
    int  configs_loaded = 0;
    int  cycle_count    = 0;
    int  status_seen [5];
    bit  src_idle       = 1'b1;
    bit  sink_idle      = 1'b1;
    int  long_hold      = 0;

    // ------------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[%0t] timeout: %0d results still outstanding",
                     $time, pending_outcomes.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor: apply one request to the behavioral table, return the result
    // ------------------------------------------------------------------------
    function automatic t_outcome hash_and_check(logic cmd, logic [WORD_W-1:0] blockers,
                                                logic [WORD_W-1:0] amap);
        t_outcome            r;
        logic [WORD_W-1:0]   product;
        logic [WORD_W-1:0]   shifted;
        logic [TBL_BITS-1:0] slot;
        r = '0;
        if (cmd == CMD_BEGIN) begin
            // marks and counters clear; stored maps survive
            foreach (slot_used[k]) slot_used[k] = 1'b0;
            n_stored       = '0;
            n_constructive = '0;
            top_index      = '0;
            failed         = 1'b0;
            r.status       = ST_BEGUN;
        end else if (failed) begin
            r.status = ST_IGNORED;
        end else begin
            product       = blockers * magic_cfg;
            shifted       = product >> shift_cfg;
            slot          = shifted[TBL_BITS-1:0];
            r.table_index = slot;
            // largest index moves on a destructive hit too
            if (slot > top_index) top_index = slot;
            if (slot_used[slot]) begin
                if (map_mem[slot] != amap) begin
                    failed   = 1'b1;
                    r.status = ST_DESTRUCTIVE;
                end else begin
                    if (n_constructive != CNT_MAX) n_constructive++;
                    r.status = ST_CONSTRUCTIVE;
                end
            end else begin
                slot_used[slot] = 1'b1;
                map_mem[slot]   = amap;
                if (n_stored != CNT_MAX) n_stored++;
                r.status = ST_STORED;
            end
        end
        r.stored_count       = n_stored;
        r.constructive_count = n_constructive;
        r.largest_index      = top_index;
        r.trial_failed       = failed;
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Blocker set that lands on a given slot when magic is 1 and shift is 52.
    function automatic logic [WORD_W-1:0] key_for_slot(logic [TBL_BITS-1:0] slot);
        logic [WORD_W-1:0] r;
        r = rand64();
        return {slot, r[WORD_W-TBL_BITS-1:0]};
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. Valid stays up across back-to-back requests; the
    // prediction is taken at the accepting edge.
    // ------------------------------------------------------------------------
    task automatic send_request(logic cmd, logic [WORD_W-1:0] blockers,
                                logic [WORD_W-1:0] amap);
        if (src_idle && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_blocker_set <= blockers;
        i_attack_map  <= amap;
        do @(posedge i_clk); while (!o_in_ready);
        pending_outcomes.insert(pending_outcomes.size(), hash_and_check(cmd, blockers, amap));
        requests_sent++;
    endtask

    // Drop valid and wait for every outstanding result.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    // Both registers, back to back; only call with the block idle.
    task automatic configure(logic [WORD_W-1:0] magic, logic [SHIFT_W-1:0] shift);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_MAGIC;
        i_cfg_data  <= magic;
        @(posedge i_clk);
        magic_cfg    = magic;
        i_cfg_index <= REG_SHIFT;
        i_cfg_data  <= WORD_W'(shift);
        @(posedge i_clk);
        shift_cfg = shift;
        i_cfg_we <= 1'b0;
        configs_loaded++;
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall bursts, plus one long hold when requested.
    // The long hold is counted here so the sender keeps pushing meanwhile.
    // ------------------------------------------------------------------------
    initial begin : sink_stall
        int n;
        forever begin
            @(posedge i_clk);
            if (long_hold != 0) begin
                n           = long_hold;
                long_hold   = 0;
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else if (sink_idle && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic note_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] %s mismatch: expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Compare each accepted result with the oldest prediction.
    always @(posedge i_clk) begin : result_monitor
        t_outcome want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] result with no request outstanding: status %0d",
                             $time, o_status);
            end else begin
                want = pending_outcomes.pop_front();
                note_field("table_index",        want.table_index,        o_table_index);
                note_field("status",             want.status,             o_status);
                note_field("stored_count",       want.stored_count,       o_stored_count);
                note_field("constructive_count", want.constructive_count,
                           o_constructive_count);
                note_field("largest_index",      want.largest_index,      o_largest_index);
                note_field("trial_failed",       want.trial_failed,       o_trial_failed);
                status_seen[int'(want.status)]++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset config: magic 0 sends every blocker set to slot 0.
    task automatic test_reset_defaults();
        logic [WORD_W-1:0] amap;
        amap = rand64();
        send_request(CMD_CHECK, rand64(), amap);
        send_request(CMD_CHECK, '1, amap);
        send_request(CMD_BEGIN, rand64(), rand64());
    endtask

    // All-ones magic and blockers, zero and all-ones maps, shift 52/63/0.
    task automatic test_field_extremes();
        wait_idle();
        configure('1, 6'd52);
        send_request(CMD_CHECK, 64'd1, '0);                      // slot 0xfff
        send_request(CMD_CHECK, '1, '1);                         // product 1 -> slot 0
        send_request(CMD_CHECK, '0, '1);                         // same map at 0
        send_request(CMD_CHECK, 64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555);
        wait_idle();
        // one-bit index
        configure('1, 6'd63);
        send_request(CMD_BEGIN, '1, '0);
        send_request(CMD_CHECK, 64'd1, 64'haaaa_aaaa_aaaa_aaaa);
        send_request(CMD_CHECK, '1, 64'haaaa_aaaa_aaaa_aaaa);
        wait_idle();
        // shift below 52: index keeps only the low bits of the product
        configure(64'h0123_4567_89ab_cdef, 6'd0);
        send_request(CMD_BEGIN, '0, '1);
        send_request(CMD_CHECK, rand64(), rand64());
        send_request(CMD_CHECK, rand64(), rand64());
        send_request(CMD_CHECK, '1, rand64());
    endtask

    // Destructive hit, ignore-after-failure, begin keeps maps but clears marks.
    task automatic test_failure_rules();
        logic [WORD_W-1:0] map_a;
        map_a = rand64();
        wait_idle();
        configure(64'd1, 6'd52);
        send_request(CMD_BEGIN, rand64(), rand64());
        send_request(CMD_CHECK, key_for_slot(12'h234), map_a);   // stored
        send_request(CMD_CHECK, key_for_slot(12'h234), ~map_a);  // destructive
        send_request(CMD_CHECK, key_for_slot(12'hfff), map_a);   // ignored, max holds
        send_request(CMD_BEGIN, rand64(), rand64());
        send_request(CMD_CHECK, key_for_slot(12'h234), ~map_a);  // free again
        send_request(CMD_CHECK, key_for_slot(12'h100), ~map_a);  // max stays 0x234
    endtask

    // One trial: begin, then checks drawn from a small pool of blocker sets
    // with consistent maps, plus occasional wrong maps and stray entries.
    task automatic run_trial(int n_checks, bit shared_map);
        logic [WORD_W-1:0] pool_b [16];
        logic [WORD_W-1:0] pool_m [16];
        logic [WORD_W-1:0] common;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] m;
        int                pool_n;
        int                k;
        pool_n = $urandom_range(1, 16);
        common = rand64();
        for (k = 0; k < pool_n; k++) begin
            // sparse sets look like real occupancy masks
            pool_b[k] = ($urandom_range(0, 1) != 0) ? rand64() : rand64() & rand64() & rand64();
            pool_m[k] = shared_map ? common : rand64();
        end
        send_request(CMD_BEGIN, rand64(), rand64());
        repeat (n_checks) begin
            k = $urandom_range(0, pool_n - 1);
            b = pool_b[k];
            m = pool_m[k];
            case ($urandom_range(0, 19))
                0:       m = rand64();
                1:       b = rand64();
                default: ;
            endcase
            send_request(CMD_CHECK, b, m);
        end
    endtask

    function automatic logic [SHIFT_W-1:0] pick_shift();
        case ($urandom_range(0, 5))
            0:       return 6'd52;
            1:       return 6'd63;
            2, 3:    return SHIFT_W'($urandom_range(52, 63));
            4:       return SHIFT_W'($urandom_range(57, 63));  // tiny table, many hits
            default: return SHIFT_W'($urandom_range(0, 51));   // wrapped index
        endcase
    endfunction

    // Phases of random trials, each under a fresh config. Each phase starts
    // from a drained block; idling rotates through both/sender/receiver/none.
    task automatic test_random_trials(int budget, bit with_idle);
        int phase;
        int start;
        phase = 0;
        start = requests_sent;
        while (requests_sent - start < budget) begin
            wait_idle();
            configure(($urandom_range(0, 3) == 0) ? rand64() & rand64() : rand64(),
                      pick_shift());
            src_idle  = with_idle && (phase % 4 == 0 || phase % 4 == 1);
            sink_idle = with_idle && (phase % 4 == 0 || phase % 4 == 2);
            // fill the block and stall its result side for a while
            if (with_idle && phase == 1) long_hold = 300;
            repeat (4)
                run_trial(($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(1, 12),
                          $urandom_range(0, 2) == 0);
            phase++;
        end
    endtask

    // Many begins, slots revisited every 13 trials with new maps: a stale
    // occupancy tag would show up as a hit instead of a fresh store.
    task automatic test_epoch_wrap();
        int t;
        wait_idle();
        configure(64'd1, 6'd52);
        for (t = 0; t < 260; t++) begin
            send_request(CMD_BEGIN, rand64(), rand64());
            send_request(CMD_CHECK, key_for_slot(TBL_BITS'(t % 13)), rand64());
        end
    endtask

    // Magic 0 keeps hitting slot 0 with the same map, back to back.
    task automatic test_constructive_run();
        logic [WORD_W-1:0] amap;
        amap = rand64();
        wait_idle();
        configure('0, 6'd52);
        send_request(CMD_BEGIN, rand64(), rand64());
        repeat (100) send_request(CMD_CHECK, rand64(), amap);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_field_extremes();
        test_failure_rules();
        test_random_trials(900, 1'b1);
        test_epoch_wrap();

        // closing stretch runs without idling
        wait_idle();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        test_random_trials(250, 1'b0);
        test_constructive_run();

        wait_idle();
        repeat (20) @(posedge i_clk);

        $display("Run covered %0d requests over %0d configurations, %0d cycles.",
                 requests_sent, configs_loaded, cycle_count);
        $display("Results: %0d stored, %0d constructive, %0d destructive, %0d ignored, %s",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 $sformatf("%0d begin; %0d mismatches.", status_seen[4], mismatches));
        if (mismatches == 0 && pending_outcomes.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/micc_pkg.sv
design/micc_ram.sv
design/micc_ctrl.sv
design/micc_datapath.sv
design/magic_index_collision_check_core.sv
tb/sv/magic_index_collision_check_core_tb.sv
